// ===== hw/rtl/sd_spi_mode_host_engine_core_defines.svh =====
// Assertion macros for the SD SPI host engine
`ifndef SD_SPI_MODE_HOST_ENGINE_CORE_DEFINES_SVH
`define SD_SPI_MODE_HOST_ENGINE_CORE_DEFINES_SVH
// implication checked on every clock edge, reset gated
`define SDH_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication checked on the following cycle
`define SDH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hw/rtl/sdh_pkg.sv =====
// ----------------------------------------------------------------------------
// sdh_pkg
// Shared types and constants of the SD SPI host engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sdh_pkg;
	localparam int BLOCK_BYTES = 512;
	localparam int IN_W = 3 + 32 + 32 + 8 + 8;
	localparam int IN_TW = 88;
	localparam int OUT_W = 1 + 8 + 1 + 1 + 1 + 8 + 1 + 3 + 8 + 2;
	localparam int OUT_TW = 40;
	localparam int QDEPTH = 2;

	localparam logic [2:0] ACT_INIT = 3'd0;
	localparam logic [2:0] ACT_READ = 3'd1;
	localparam logic [2:0] ACT_WRITE = 3'd2;
	localparam logic [2:0] ACT_ERASE = 3'd3;
	localparam logic [2:0] ACT_XFER = 3'd4;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOCARD = 3'd1;
	localparam logic [2:0] ST_INITFAIL = 3'd2;
	localparam logic [2:0] ST_TIMEOUT = 3'd3;
	localparam logic [2:0] ST_REJECT = 3'd4;

	localparam logic [1:0] CFG_RESP_POLL = 2'd0;
	localparam logic [1:0] CFG_INIT_ATT = 2'd1;
	localparam logic [1:0] CFG_DATA_POLL = 2'd2;

	typedef struct packed {
		logic [2:0] action;
		logic [31:0] block_addr;
		logic [31:0] block_count;
		logic [7:0] rx_byte;
		logic [7:0] payload_byte;
	} sdh_item_t;

	typedef struct packed {
		logic [1:0] card_kind;
		logic [7:0] card_response;
		logic [2:0] status;
		logic done_res;
		logic [7:0] read_byte;
		logic read_valid;
		logic payload_wanted;
		logic chip_select;
		logic [7:0] tx_byte;
		logic tx_valid;
	} sdh_res_t;

	typedef struct packed {
		logic [8:0] resp_poll;
		logic [8:0] init_att;
		logic [16:0] data_poll;
	} sdh_cfg_t;
endpackage
`default_nettype wire

// ===== hw/rtl/sdh_front.sv =====
// ----------------------------------------------------------------------------
// sdh_front
// Accepts stream words, unpacks them and queues them for the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sdh_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [sdh_pkg::IN_TW-1:0] tdata,
	input wire logic tvalid,
	output logic tready,
	output sdh_pkg::sdh_item_t item,
	output logic item_valid,
	input wire logic item_take
);
	import sdh_pkg::*;
	sdh_item_t mem_q [QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;
	sdh_item_t in_item;

	// action lowest, payload_byte highest
	assign in_item.action = tdata[2:0];
	assign in_item.block_addr = tdata[34:3];
	assign in_item.block_count = tdata[66:35];
	assign in_item.rx_byte = tdata[74:67];
	assign in_item.payload_byte = tdata[82:75];

	assign tready = (cnt_q != 2'd2);
	assign push = tvalid && tready;
	assign item_valid = (cnt_q != 2'd0);
	assign item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (item_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_take};
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sdh_back.sv =====
// ----------------------------------------------------------------------------
// sdh_back
// Card sequencer: one queued word per cycle into the output register unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sdh_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire sdh_pkg::sdh_cfg_t cfg,
	input wire sdh_pkg::sdh_item_t item,
	input wire logic item_valid,
	output logic item_take,
	output logic [sdh_pkg::OUT_TW-1:0] tdata,
	output logic tvalid,
	input wire logic tready,
	output logic busy
);
	import sdh_pkg::*;

	typedef enum logic [12:0] {
		PH_IDLE = 13'h0001, PH_PRECLK = 13'h0002, PH_CMD = 13'h0004,
		PH_POLL = 13'h0008, PH_OCR = 13'h0010, PH_TAIL = 13'h0020,
		PH_GAP = 13'h0040, PH_TOKEN = 13'h0080, PH_RDATA = 13'h0100,
		PH_WDATA = 13'h0200, PH_BUSY1 = 13'h0400, PH_WGAP = 13'h0800,
		PH_BUSY2 = 13'h1000
	} phase_t;

	phase_t ph_q, ph_d;
	logic [3:0] stg_q, stg_d;
	logic [9:0] bi_q, bi_d;
	logic [16:0] rc_q, rc_d;
	logic [8:0] ac_q, ac_d;
	logic [5:0] cc_q, cc_d;
	logic [31:0] arg_q, arg_d, ee_q, ee_d;
	logic hc_q, hc_d, v2_q, v2_d;
	logic [1:0] kind_q, kind_d, pr_q, pr_d;
	logic [7:0] lr_q, lr_d;
	sdh_res_t r, out_q;
	logic ov_q;
	logic [16:0] rc_inc;
	logic [8:0] ac_inc;
	logic [8:0] rlim, alim;

	assign item_take = item_valid && (!ov_q || tready);
	assign tvalid = ov_q;
	assign tdata = {{(OUT_TW-OUT_W){1'b0}}, out_q};
	assign busy = (ph_q != PH_IDLE) || ov_q || item_valid;
	assign rc_inc = rc_q + 17'd1;
	assign ac_inc = ac_q + 9'd1;
	assign rlim = cfg.resp_poll;
	assign alim = cfg.init_att;

	always_comb begin
		logic [5:0] ncode;
		logic [31:0] narg;
		logic cmd_go, fin, rsp_zero, over, pov;
		logic [2:0] fst;
		logic [7:0] fresp;
		logic [7:0] ob;
		logic [7:0] rx;
		ncode = '0; narg = '0; cmd_go = 1'b0; fin = 1'b0; fst = ST_OK; fresp = '0;
		rsp_zero = 1'b0; over = 1'b0; pov = 1'b0; ob = '0; rx = item.rx_byte;
		ph_d = ph_q; stg_d = stg_q; bi_d = bi_q; rc_d = rc_q; ac_d = ac_q;
		cc_d = cc_q; arg_d = arg_q; ee_d = ee_q; hc_d = hc_q; v2_d = v2_q;
		kind_d = kind_q; pr_d = pr_q; lr_d = lr_q;
		r = '0;
		if (ph_q == PH_IDLE) begin
			case (item.action)
				ACT_INIT: begin
					pr_d = 2'd0; kind_d = 2'd0; ph_d = PH_PRECLK; bi_d = '0;
					r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
				end
				ACT_READ: begin
					pr_d = 2'd1; cmd_go = 1'b1; ncode = 6'd17; narg = item.block_addr;
				end
				ACT_WRITE: begin
					pr_d = 2'd2; cmd_go = 1'b1; ncode = 6'd24; narg = item.block_addr;
				end
				ACT_ERASE: begin
					pr_d = 2'd3; cmd_go = 1'b1; ncode = 6'd32; narg = item.block_addr;
					ee_d = item.block_addr + item.block_count - 32'd1;
				end
				default: ;
			endcase
		end else if (item.action == ACT_XFER) begin
			case (ph_q)
				PH_PRECLK: begin
					bi_d = bi_q + 10'd1;
					if (bi_d >= 10'd16) begin
						stg_d = 4'd0; ac_d = '0; cmd_go = 1'b1; ncode = 6'd0; narg = '0;
					end else begin
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end
				end
				PH_CMD: begin
					if (bi_q < 10'd5) begin
						bi_d = bi_q + 10'd1;
						case (bi_d[2:0])
							3'd1: ob = arg_q[31:24];
							3'd2: ob = arg_q[23:16];
							3'd3: ob = arg_q[15:8];
							3'd4: ob = arg_q[7:0];
							default: ob = (cc_q == 6'd8) ? 8'h87 : 8'h95;
						endcase
						r.tx_valid = 1'b1; r.tx_byte = ob; r.chip_select = 1'b1;
					end else begin
						ph_d = PH_POLL; rc_d = '0;
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.chip_select = 1'b1;
					end
				end
				PH_POLL: begin
					rc_d = rc_inc;
					if (rc_inc >= {8'd0, rlim} || rx != 8'hFF) begin
						lr_d = rx;
						if (rx == 8'h00 && cc_q == 6'd58) begin
							ph_d = PH_OCR; bi_d = '0;
							r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.chip_select = 1'b1;
						end else begin
							ph_d = PH_TAIL; r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
						end
					end else begin
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.chip_select = 1'b1;
					end
				end
				PH_OCR: begin
					if (bi_q == 10'd0) hc_d = rx[6];
					bi_d = bi_q + 10'd1;
					r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					if (bi_d >= 10'd4) ph_d = PH_TAIL;
					else r.chip_select = 1'b1;
				end
				PH_TAIL: begin
					rsp_zero = (lr_q == 8'h00);
					over = (ac_inc >= alim);
					if (pr_q == 2'd0) begin
						case (stg_q)
							4'd0: begin
								ac_d = ac_inc;
								if (over) begin fin = 1'b1; fst = ST_NOCARD; end
								else if (lr_q == 8'h01) begin
									ph_d = PH_GAP; bi_d = '0;
									r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
								end else begin cmd_go = 1'b1; ncode = 6'd0; end
							end
							4'd2: begin
								ac_d = ac_inc;
								if (over) begin
									v2_d = 1'b0; kind_d = 2'd1; ac_d = '0;
									stg_d = 4'd3; cmd_go = 1'b1; ncode = 6'd55;
								end else if (lr_q == 8'h01) begin
									ac_d = '0; stg_d = 4'd3; cmd_go = 1'b1; ncode = 6'd55;
								end else begin
									cmd_go = 1'b1; ncode = 6'd8; narg = 32'h000001AA;
								end
							end
							4'd3: begin
								stg_d = 4'd4; cmd_go = 1'b1; ncode = 6'd41; narg = 32'h40000000;
							end
							4'd4: begin
								ac_d = ac_inc;
								if (over) begin fin = 1'b1; fst = ST_INITFAIL; end
								else if (rsp_zero) begin
									hc_d = 1'b0; ac_d = '0; cmd_go = 1'b1;
									if (v2_q) begin stg_d = 4'd5; ncode = 6'd58; end
									else begin stg_d = 4'd6; ncode = 6'd59; end
								end else begin stg_d = 4'd3; cmd_go = 1'b1; ncode = 6'd55; end
							end
							4'd5: begin
								ac_d = ac_inc;
								if (over) begin
									kind_d = 2'd0; stg_d = 4'd6; cmd_go = 1'b1; ncode = 6'd59;
								end else if (rsp_zero) begin
									kind_d = hc_q ? 2'd2 : 2'd3;
									stg_d = 4'd6; cmd_go = 1'b1; ncode = 6'd59;
								end else begin cmd_go = 1'b1; ncode = 6'd58; end
							end
							4'd6: begin
								stg_d = 4'd7; cmd_go = 1'b1; ncode = 6'd16;
								narg = 32'(BLOCK_BYTES);
							end
							default: fin = 1'b1;
						endcase
					end else if (!rsp_zero) begin
						fin = 1'b1; fst = ST_REJECT; fresp = lr_q;
					end else if (pr_q == 2'd1) begin
						ph_d = PH_TOKEN; rc_d = '0;
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.chip_select = 1'b1;
					end else if (pr_q == 2'd2) begin
						ph_d = PH_WDATA; bi_d = '0; r.payload_wanted = 1'b1;
						r.tx_valid = 1'b1; r.tx_byte = 8'hFE; r.chip_select = 1'b1;
					end else if (cc_q == 6'd32) begin
						cmd_go = 1'b1; ncode = 6'd33; narg = ee_q;
					end else if (cc_q == 6'd33) begin
						cmd_go = 1'b1; ncode = 6'd38;
					end else fin = 1'b1;
				end
				PH_GAP: begin
					bi_d = bi_q + 10'd1;
					if (bi_d >= 10'd2) begin
						v2_d = 1'b1; ac_d = '0; stg_d = 4'd2;
						cmd_go = 1'b1; ncode = 6'd8; narg = 32'h000001AA;
					end else begin
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
					end
				end
				PH_TOKEN, PH_BUSY1, PH_BUSY2: begin
					rc_d = rc_inc;
					pov = (rc_inc >= cfg.data_poll);
					if (ph_q == PH_TOKEN ? (rx == 8'hFE) : (rx != 8'h00)) begin
						rc_d = rc_q;
						if (ph_q == PH_TOKEN) begin
							ph_d = PH_RDATA; bi_d = '0;
							r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.chip_select = 1'b1;
						end else if (ph_q == PH_BUSY1) begin
							ph_d = PH_WGAP; r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
						end else fin = 1'b1;
					end else if (pov) begin
						fin = 1'b1; fst = ST_TIMEOUT;
					end else begin
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.chip_select = 1'b1;
					end
				end
				PH_RDATA: begin
					if (bi_q < 10'(BLOCK_BYTES)) begin
						r.read_valid = 1'b1; r.read_byte = rx;
					end
					bi_d = bi_q + 10'd1;
					if ({1'b0, bi_q} + 11'd1 >= 11'(BLOCK_BYTES + 3)) fin = 1'b1;
					else begin
						r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.chip_select = 1'b1;
					end
				end
				PH_WDATA: begin
					bi_d = bi_q + 10'd1;
					r.tx_valid = 1'b1; r.chip_select = 1'b1;
					if ({1'b0, bi_q} + 11'd1 <= 11'(BLOCK_BYTES)) begin
						r.tx_byte = item.payload_byte;
						if ({1'b0, bi_q} + 11'd1 < 11'(BLOCK_BYTES)) r.payload_wanted = 1'b1;
					end else begin
						r.tx_byte = 8'hFF;
						if ({1'b0, bi_q} + 11'd1 > 11'(BLOCK_BYTES + 3)) begin
							ph_d = PH_BUSY1; rc_d = '0;
						end
					end
				end
				PH_WGAP: begin
					ph_d = PH_BUSY2;
					r.tx_valid = 1'b1; r.tx_byte = 8'hFF; r.chip_select = 1'b1;
				end
				default: ph_d = PH_IDLE;
			endcase
		end
		if (cmd_go) begin
			cc_d = ncode;
			if (!hc_d && (ncode == 6'd17 || ncode == 6'd18 || ncode == 6'd24 ||
					ncode == 6'd25 || ncode == 6'd32 || ncode == 6'd33))
				arg_d = {narg[22:0], 9'd0};
			else
				arg_d = narg;
			bi_d = '0; rc_d = '0; ph_d = PH_CMD;
			r.tx_valid = 1'b1; r.tx_byte = {2'b01, ncode}; r.chip_select = 1'b1;
		end
		if (fin) begin
			ph_d = PH_IDLE; r.done_res = 1'b1; r.status = fst; r.card_response = fresp;
		end
		r.card_kind = kind_d;
	end

	always_ff @(posedge clk) begin
		if (item_take) out_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE; stg_q <= '0; bi_q <= '0; rc_q <= '0; ac_q <= '0;
			cc_q <= '0; arg_q <= '0; ee_q <= '0; hc_q <= 1'b0; v2_q <= 1'b0;
			kind_q <= '0; pr_q <= '0; lr_q <= '0; ov_q <= 1'b0;
		end else begin
			if (item_take) begin
				ph_q <= ph_d; stg_q <= stg_d; bi_q <= bi_d; rc_q <= rc_d; ac_q <= ac_d;
				cc_q <= cc_d; arg_q <= arg_d; ee_q <= ee_d; hc_q <= hc_d; v2_q <= v2_d;
				kind_q <= kind_d; pr_q <= pr_d; lr_q <= lr_d;
			end
			if (item_take) ov_q <= 1'b1;
			else if (tready) ov_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sd_spi_mode_host_engine_core.sv =====
// ----------------------------------------------------------------------------
// sd_spi_mode_host_engine_core
// SD card host in SPI mode: request and exchange words in, next-byte words out.
// ----------------------------------------------------------------------------
// Usage:
// - s_axis carries one word per host request or finished SPI exchange;
//   every accepted word yields exactly one m_axis result word.
// - The front queue (2 entries) takes words; unless m_axis stalls, the
//   sequencer retires one queued word per cycle into the output register,
//   so throughput is one word per cycle; words pass the queue, then that register.
// - cfg_* writes the three limit registers (index 0 response poll,
//   1 init attempts, 2 data poll); take them only while the engine is idle.
// - Reset clears all sequencer state and loads the limit defaults
//   (256, 255, 65536); no word is pending after reset.
// - When m_axis_tready is low the output register holds, the sequencer
//   stops, and the queue fills; s_axis_tready falls once it holds two words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sd_spi_mode_host_engine_core_defines.svh"
module sd_spi_mode_host_engine_core (
	input wire logic clk,
	input wire logic arst_n,
	// action[2:0], block_addr[34:3], block_count[66:35], rx_byte[74:67],
	// payload_byte[82:75]
	input wire logic [sdh_pkg::IN_TW-1:0] s_axis_tdata,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// tx_valid[0], tx_byte[8:1], chip_select[9], payload_wanted[10],
	// read_valid[11], read_byte[19:12], done_res[20], status[23:21],
	// card_response[31:24], card_kind[33:32]
	output logic [sdh_pkg::OUT_TW-1:0] m_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [16:0] cfg_data
);
	import sdh_pkg::*;
	sdh_cfg_t cfg_q;
	sdh_item_t item;
	logic item_valid, item_take, busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resp_poll <= 9'd256;
			cfg_q.init_att <= 9'd255;
			cfg_q.data_poll <= 17'd65536;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RESP_POLL: cfg_q.resp_poll <= cfg_data[8:0];
				CFG_INIT_ATT: cfg_q.init_att <= cfg_data[8:0];
				CFG_DATA_POLL: cfg_q.data_poll <= cfg_data;
				default: ;
			endcase
		end
	end

	sdh_front u_front (
		.clk, .arst_n, .tdata(s_axis_tdata), .tvalid(s_axis_tvalid),
		.tready(s_axis_tready), .item, .item_valid, .item_take
	);

	sdh_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .item, .item_valid, .item_take,
		.tdata(m_axis_tdata), .tvalid(m_axis_tvalid), .tready(m_axis_tready), .busy
	);

	// sequencer retires nothing while the result register is stalled
	`SDH_ASSERT_IMPL(a_no_take_stalled, m_axis_tvalid && !m_axis_tready, !item_take, "take while stalled")
	// a retired word always shows a result next cycle
	`SDH_ASSERT_NEXT(a_take_shows, item_take, m_axis_tvalid, "result missing")
	// a word is retired only from a nonempty queue
	`SDH_ASSERT_IMPL(a_take_needs_item, item_take, item_valid && busy, "take without item")
endmodule
`default_nettype wire

// ===== bench/sd_spi_mode_host_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// sd_spi_mode_host_engine_core_tb
// Drives host requests and SPI exchange words into the SD SPI host engine.
// Card replies are picked from a shadow copy of the engine state, so most
// requests see well-formed command, token and busy sequences. Each accepted
// word is run through a bit-exact sequencer model and the result words are
// checked in order, under several limit settings and random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sd_spi_mode_host_engine_core_tb;
	import sdh_pkg::*;

	// sequencer phases
	typedef enum logic [4:0] {
		P_IDLE, P_PRECLK, P_CMD, P_POLL, P_OCR, P_TAIL, P_GAP,
		P_TOKEN, P_RDATA, P_WDATA, P_BUSY1, P_WGAP, P_BUSY2
	} seq_phase_t;

	typedef struct {
		seq_phase_t ph;
		logic [3:0] stage;
		logic [9:0] idx;
		logic [16:0] retries;
		logic [8:0] attempts;
		logic [5:0] cmd;
		logic [31:0] arg;
		logic [31:0] erase_last;
		bit hc;
		bit v2;
		logic [1:0] kind;
		logic [1:0] req;
		logic [7:0] resp;
	} eng_state_t;

	typedef struct {
		int unsigned rpoll;
		int unsigned tries;
		int unsigned dpoll;
	} limits_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_TW-1:0] s_axis_tdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [OUT_TW-1:0] m_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [16:0] cfg_data = '0;

	sd_spi_mode_host_engine_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// limits as the engine holds them; changed only while it is idle
	limits_t lim = '{256, 255, 65536};
	eng_state_t exp_st;   // advanced on accepted words
	eng_state_t plan_st;  // advanced as words are queued
	logic [IN_TW-1:0] pending_words[$];
	sdh_res_t expected_words[$];
	int results_seen = 0;
	int errors = 0;
	int words_planned = 0;
	int req_count[4] = '{0, 0, 0, 0};
	int rd_bytes = 0;
	int hold_left = 0;
	bit hold_done = 0;
	bit quiet;

	// no idling on either side over this window
	assign quiet = (results_seen >= 1000) && (results_seen < 1300);

	// ---------------------------------------------------------------- model
	function automatic eng_state_t fresh_state();
		eng_state_t s;
		s.ph = P_IDLE;
		s.stage = '0;
		s.idx = '0;
		s.retries = '0;
		s.attempts = '0;
		s.cmd = '0;
		s.arg = '0;
		s.erase_last = '0;
		s.hc = 0;
		s.v2 = 0;
		s.kind = '0;
		s.req = '0;
		s.resp = '0;
		return s;
	endfunction

	function automatic void send(inout sdh_res_t r, input logic [7:0] b, input bit cs);
		r.tx_valid = 1'b1;
		r.tx_byte = b;
		r.chip_select = cs;
	endfunction

	function automatic void close_req(inout eng_state_t s, inout sdh_res_t r,
			input logic [2:0] code, input logic [7:0] resp);
		s.ph = P_IDLE;
		r.done_res = 1'b1;
		r.status = code;
		r.card_response = resp;
	endfunction

	// block-addressed commands take byte addresses on standard-capacity cards
	function automatic void issue_cmd(inout eng_state_t s, inout sdh_res_t r,
			input logic [5:0] code, input logic [31:0] arg);
		s.cmd = code;
		if (!s.hc && (code inside {6'd17, 6'd18, 6'd24, 6'd25, 6'd32, 6'd33}))
			arg = arg << 9;
		s.arg = arg;
		s.idx = '0;
		s.retries = '0;
		s.ph = P_CMD;
		send(r, 8'h40 | code, 1'b1);
	endfunction

	function automatic bit tries_out(inout eng_state_t s);
		s.attempts = s.attempts + 1'b1;
		return s.attempts >= lim.tries;
	endfunction

	function automatic bit polls_out(inout eng_state_t s, input int unsigned limit);
		s.retries = s.retries + 1'b1;
		return s.retries >= limit;
	endfunction

	function automatic logic [7:0] frame_byte(input eng_state_t s);
		case (s.idx)
			0: return 8'h40 | s.cmd;
			1: return s.arg[31:24];
			2: return s.arg[23:16];
			3: return s.arg[15:8];
			4: return s.arg[7:0];
			default: return (s.cmd == 6'd8) ? 8'h87 : 8'h95;
		endcase
	endfunction

	// init sequence and request follow-up, once a command's tail clock is done
	function automatic void after_cmd(inout eng_state_t s, inout sdh_res_t r);
		logic [7:0] rsp;
		rsp = s.resp;
		if (s.req == 2'd0) begin
			case (s.stage)
				4'd0: begin
					if (tries_out(s)) close_req(s, r, ST_NOCARD, 8'h00);
					else if (rsp == 8'h01) begin
						s.ph = P_GAP;
						s.idx = '0;
						send(r, 8'hFF, 1'b0);
					end else issue_cmd(s, r, 6'd0, 32'h0);
				end
				4'd2: begin
					if (tries_out(s)) begin
						// no CMD8 answer: version 1 card
						s.v2 = 0;
						s.kind = 2'd1;
						s.attempts = '0;
						s.stage = 4'd3;
						issue_cmd(s, r, 6'd55, 32'h0);
					end else if (rsp == 8'h01) begin
						s.attempts = '0;
						s.stage = 4'd3;
						issue_cmd(s, r, 6'd55, 32'h0);
					end else issue_cmd(s, r, 6'd8, 32'h0000_01AA);
				end
				4'd3: begin
					s.stage = 4'd4;
					issue_cmd(s, r, 6'd41, 32'h4000_0000);
				end
				4'd4: begin
					if (tries_out(s)) close_req(s, r, ST_INITFAIL, 8'h00);
					else if (rsp == 8'h00) begin
						s.hc = 0;
						s.attempts = '0;
						if (s.v2) begin
							s.stage = 4'd5;
							issue_cmd(s, r, 6'd58, 32'h0);
						end else begin
							s.stage = 4'd6;
							issue_cmd(s, r, 6'd59, 32'h0);
						end
					end else begin
						s.stage = 4'd3;
						issue_cmd(s, r, 6'd55, 32'h0);
					end
				end
				4'd5: begin
					if (tries_out(s)) begin
						s.kind = 2'd0;
						s.stage = 4'd6;
						issue_cmd(s, r, 6'd59, 32'h0);
					end else if (rsp == 8'h00) begin
						s.kind = s.hc ? 2'd2 : 2'd3;
						s.stage = 4'd6;
						issue_cmd(s, r, 6'd59, 32'h0);
					end else issue_cmd(s, r, 6'd58, 32'h0);
				end
				4'd6: begin
					s.stage = 4'd7;
					issue_cmd(s, r, 6'd16, BLOCK_BYTES);
				end
				default: close_req(s, r, ST_OK, 8'h00);
			endcase
		end else if (rsp != 8'h00) begin
			close_req(s, r, ST_REJECT, rsp);
		end else if (s.req == 2'd1) begin
			s.ph = P_TOKEN;
			s.retries = '0;
			send(r, 8'hFF, 1'b1);
		end else if (s.req == 2'd2) begin
			s.ph = P_WDATA;
			s.idx = '0;
			send(r, 8'hFE, 1'b1);
			r.payload_wanted = 1'b1;
		end else if (s.cmd == 6'd32) issue_cmd(s, r, 6'd33, s.erase_last);
		else if (s.cmd == 6'd33) issue_cmd(s, r, 6'd38, 32'h0);
		else close_req(s, r, ST_OK, 8'h00);
	endfunction

	function automatic void on_exchange(inout eng_state_t s, inout sdh_res_t r,
			input logic [7:0] rx, input logic [7:0] pay);
		bit over;
		case (s.ph)
			P_PRECLK: begin
				s.idx++;
				if (s.idx >= 16) begin
					s.stage = 4'd0;
					s.attempts = '0;
					issue_cmd(s, r, 6'd0, 32'h0);
				end else send(r, 8'hFF, 1'b0);
			end
			P_CMD: begin
				if (s.idx < 5) begin
					s.idx++;
					send(r, frame_byte(s), 1'b1);
				end else begin
					s.ph = P_POLL;
					s.retries = '0;
					send(r, 8'hFF, 1'b1);
				end
			end
			P_POLL: begin
				over = polls_out(s, lim.rpoll);
				if (over || rx != 8'hFF) begin
					s.resp = rx;
					if (rx == 8'h00 && s.cmd == 6'd58) begin
						s.ph = P_OCR;
						s.idx = '0;
						send(r, 8'hFF, 1'b1);
					end else begin
						s.ph = P_TAIL;
						send(r, 8'hFF, 1'b0);
					end
				end else send(r, 8'hFF, 1'b1);
			end
			P_OCR: begin
				if (s.idx == 0) s.hc = rx[6];
				s.idx++;
				if (s.idx >= 4) begin
					s.ph = P_TAIL;
					send(r, 8'hFF, 1'b0);
				end else send(r, 8'hFF, 1'b1);
			end
			P_TAIL: after_cmd(s, r);
			P_GAP: begin
				s.idx++;
				if (s.idx >= 2) begin
					s.v2 = 1;
					s.attempts = '0;
					s.stage = 4'd2;
					issue_cmd(s, r, 6'd8, 32'h0000_01AA);
				end else send(r, 8'hFF, 1'b0);
			end
			P_TOKEN: begin
				if (rx == 8'hFE) begin
					s.ph = P_RDATA;
					s.idx = '0;
					send(r, 8'hFF, 1'b1);
				end else if (polls_out(s, lim.dpoll)) close_req(s, r, ST_TIMEOUT, 8'h00);
				else send(r, 8'hFF, 1'b1);
			end
			P_RDATA: begin
				if (s.idx < BLOCK_BYTES) begin
					r.read_valid = 1'b1;
					r.read_byte = rx;
				end
				s.idx++;
				if (s.idx >= BLOCK_BYTES + 3) close_req(s, r, ST_OK, 8'h00);
				else send(r, 8'hFF, 1'b1);
			end
			P_WDATA: begin
				s.idx++;
				if (s.idx <= BLOCK_BYTES) begin
					send(r, pay, 1'b1);
					if (s.idx < BLOCK_BYTES) r.payload_wanted = 1'b1;
				end else if (s.idx <= BLOCK_BYTES + 3) send(r, 8'hFF, 1'b1);
				else begin
					s.ph = P_BUSY1;
					s.retries = '0;
					send(r, 8'hFF, 1'b1);
				end
			end
			P_BUSY1: begin
				if (rx != 8'h00) begin
					s.ph = P_WGAP;
					send(r, 8'hFF, 1'b0);
				end else if (polls_out(s, lim.dpoll)) close_req(s, r, ST_TIMEOUT, 8'h00);
				else send(r, 8'hFF, 1'b1);
			end
			P_WGAP: begin
				s.ph = P_BUSY2;
				send(r, 8'hFF, 1'b1);
			end
			P_BUSY2: begin
				if (rx != 8'h00) close_req(s, r, ST_OK, 8'h00);
				else if (polls_out(s, lim.dpoll)) close_req(s, r, ST_TIMEOUT, 8'h00);
				else send(r, 8'hFF, 1'b1);
			end
			default: s.ph = P_IDLE;
		endcase
	endfunction

	// one input word in, one result word out
	function automatic sdh_res_t sd_engine_step(inout eng_state_t s, input logic [IN_TW-1:0] w);
		sdh_res_t r;
		logic [2:0] act;
		logic [31:0] addr;
		logic [31:0] cnt;
		act = w[2:0];
		addr = w[34:3];
		cnt = w[66:35];
		r = '0;
		if (s.ph == P_IDLE) begin
			case (act)
				ACT_INIT: begin
					s.req = 2'd0;
					s.kind = 2'd0;
					s.ph = P_PRECLK;
					s.idx = '0;
					send(r, 8'hFF, 1'b0);
				end
				ACT_READ: begin
					s.req = 2'd1;
					issue_cmd(s, r, 6'd17, addr);
				end
				ACT_WRITE: begin
					s.req = 2'd2;
					issue_cmd(s, r, 6'd24, addr);
				end
				ACT_ERASE: begin
					s.req = 2'd3;
					s.erase_last = addr + cnt - 1;
					issue_cmd(s, r, 6'd32, addr);
				end
				default: ;
			endcase
		end else if (act == ACT_XFER) begin
			on_exchange(s, r, w[74:67], w[82:75]);
		end
		r.card_kind = s.kind;
		return r;
	endfunction

	// ------------------------------------------------------------ stimulus
	// card reply steering the sequence mostly toward progress
	function automatic logic [7:0] card_reply_for(input eng_state_t s);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		case (s.ph)
			P_POLL: begin
				if ($urandom_range(0, 9) < 3) return 8'hFF;
				if (s.req != 2'd0) return ($urandom_range(0, 9) != 0) ? 8'h00 : junk;
				case (s.stage)
					4'd0: return ($urandom_range(0, 7) != 0) ? 8'h01 : junk;
					4'd2: return ($urandom_range(0, 5) != 0) ? 8'h01 : 8'h05;
					4'd4: return $urandom_range(0, 1) ? 8'h00 : 8'h01;
					4'd5: return ($urandom_range(0, 7) != 0) ? 8'h00 : junk;
					default: return junk;
				endcase
			end
			P_TOKEN: return ($urandom_range(0, 3) == 0) ? 8'hFE : (junk[0] ? 8'hFF : junk);
			P_BUSY1, P_BUSY2:
				return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
			default: return junk;
		endcase
	endfunction

	task automatic queue_word(input logic [2:0] act, input logic [31:0] addr,
			input logic [31:0] cnt);
		logic [IN_TW-1:0] w;
		sdh_res_t unused;
		w = '0;
		w[2:0] = act;
		w[34:3] = addr;
		w[66:35] = cnt;
		w[74:67] = card_reply_for(plan_st);
		w[82:75] = 8'($urandom_range(0, 255));
		unused = sd_engine_step(plan_st, w);
		pending_words.push_back(w);
		words_planned++;
	endtask

	// a request and the exchanges that carry it to its end, with some noise
	task automatic run_request(input logic [2:0] act, input logic [31:0] addr,
			input logic [31:0] cnt);
		logic [2:0] stray;
		queue_word(act, addr, cnt);
		req_count[act]++;
		while (plan_st.ph != P_IDLE) begin
			if ($urandom_range(0, 19) == 0) begin
				stray = 3'($urandom_range(0, 6));
				if (stray >= ACT_XFER) stray++;
				queue_word(stray, $urandom, $urandom);
			end else queue_word(ACT_XFER, $urandom, $urandom);
		end
	endtask

	// sender holds until the engine has answered everything
	task automatic drain();
		wait (pending_words.size() == 0 && !s_axis_tvalid && expected_words.size() == 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(input int unsigned rp, input int unsigned tr,
			input int unsigned dp);
		drain();
		write_reg(CFG_RESP_POLL, 17'(rp));
		write_reg(CFG_INIT_ATT, 17'(tr));
		write_reg(CFG_DATA_POLL, 17'(dp));
		lim = '{rp, tr, dp};
	endtask

	function automatic logic [31:0] pick_addr();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------- driver
	// forms the expectation at the edge where the word is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_words.push_back(sd_engine_step(exp_st, s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_words.size() != 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
					s_axis_tdata <= pending_words.pop_front();
					s_axis_tvalid <= 1'b1;
				end else s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------- receiver, stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= (hold_left == 1);
		end else if (!hold_done && results_seen >= 300) begin
			// long back-pressure: the queue fills and s_axis_tready drops
			hold_done <= 1;
			hold_left <= 250;
			m_axis_tready <= 1'b0;
		end else m_axis_tready <= quiet || ($urandom_range(0, 99) >= 16);
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// -------------------------------------------------------------- monitor
	always @(posedge clk) begin
		sdh_res_t got;
		sdh_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[OUT_W-1:0];
			results_seen <= results_seen + 1;
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected: %h", m_axis_tdata);
				errors++;
			end else begin
				want = expected_words.pop_front();
				if (want.read_valid) rd_bytes++;
				check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
				check_field("tx_byte", want.tx_byte, got.tx_byte);
				check_field("chip_select", 8'(want.chip_select), 8'(got.chip_select));
				check_field("payload_wanted", 8'(want.payload_wanted),
					8'(got.payload_wanted));
				check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
				check_field("read_byte", want.read_byte, got.read_byte);
				check_field("done_res", 8'(want.done_res), 8'(got.done_res));
				check_field("status", 8'(want.status), 8'(got.status));
				check_field("card_response", want.card_response, got.card_response);
				check_field("card_kind", 8'(want.card_kind), 8'(got.card_kind));
			end
		end
	end

	// ------------------------------------------------------------ sequence
	initial begin
		exp_st = fresh_state();
		plan_st = fresh_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle noise, full init, erase corner cases, one read
		queue_word(ACT_XFER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(3'd5, 32'h0, 32'h0);
		queue_word(3'd6, 32'hFFFF_FFFF, 32'h0);
		queue_word(3'd7, 32'h0, 32'hFFFF_FFFF);
		run_request(ACT_INIT, 32'h0, 32'h0);
		run_request(ACT_ERASE, 32'hFFFF_FFFF, 32'h0);
		run_request(ACT_ERASE, 32'h0, 32'hFFFF_FFFF);
		run_request(ACT_READ, 32'hFFFF_FFFF, 32'h1);

		// random phases under changing limits, extremes included;
		// each phase tops the word count up toward about 1440 in total
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: set_limits(1, 1, 1);
				1: set_limits(256, 256, 65536);
				2: set_limits($urandom_range(2, 8), $urandom_range(2, 6), $urandom_range(1, 20));
				default: set_limits(16, 255, 300);
			endcase
			run_request(ACT_INIT, 32'h0, 32'h0);
			while (words_planned < 560 + 220 * (p + 1)) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5: run_request(ACT_INIT, $urandom, $urandom);
					6, 7, 8: run_request(ACT_READ, pick_addr(), $urandom);
					9, 10, 11: run_request(ACT_WRITE, pick_addr(), $urandom);
					default: run_request(ACT_ERASE, pick_addr(),
						$urandom_range(0, 3) == 0 ? 32'h0 : $urandom);
				endcase
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (expected_words.size() != 0) begin
			$error("%0d expected words never arrived", expected_words.size());
			errors++;
		end
		$display("covered %0d words: %0d init, %0d read, %0d write, %0d erase requests",
			results_seen, req_count[0], req_count[1], req_count[2], req_count[3]);
		$display("  %0d read data bytes, four limit settings, stalls on both sides", rd_bytes);
		if (errors == 0) begin
			$display("sd_spi_mode_host_engine_core_tb: done, clean");
		end else begin
			$display("sd_spi_mode_host_engine_core_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("sd_spi_mode_host_engine_core_tb: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
